@@ hw/rtl/tiled_indexed_pixel_fetch_core_macros.svh @@
// Assertion macros shared by the pixel fetch RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef TILED_INDEXED_PIXEL_FETCH_CORE_MACROS_SVH
`define TILED_INDEXED_PIXEL_FETCH_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TIPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TIPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tipf_pkg.sv @@
// Package for the tiled indexed pixel fetch: types, codes, palette and defaults.
// Depends on nothing.
`default_nettype none

package tipf_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_STORE_BYTES     = 16384;
  localparam int DEF_MAX_WIDTH_TILES = 24;

  // Result queue depth bounds the number of reads in flight
  localparam int FIFO_DEPTH = 4;
  localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

  // Field widths
  localparam int BIDX_W = 14;
  localparam int BYTE_W = 8;
  localparam int X_W    = 8;
  localparam int Y_W    = 7;
  localparam int TILE_W = 10;
  localparam int LIN_W  = 15;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = 5;

  // Configuration reset values
  localparam logic [4:0] RST_WIDTH_TILES  = 5'd24;
  localparam logic [4:0] RST_HEIGHT_TILES = 5'd16;

  localparam logic [31:0] COLOR_BLACK = 32'h0000_00FF;
  localparam logic [31:0] COLOR_WHITE = 32'hFFFF_FFFF;

  localparam logic [31:0] PALETTE [16] = '{
    32'h0000_0000, 32'h0000_00FF, 32'hFFDF_9CFF, 32'hFFAE_31FF,
    32'hFF49_00FF, 32'hFF00_00FF, 32'hCE69_EFFF, 32'h10C7_CEFF,
    32'h2969_C6FF, 32'h0896_52FF, 32'h73D7_39FF, 32'hFFFF_5AFF,
    32'h8080_80FF, 32'hC0C0_C0FF, 32'hFFFF_FFFF, 32'h4A9C_ADFF
  };

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic {
    MODE_4BPP = 1'b0,
    MODE_1BPP = 1'b1
  } mode_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_PIXEL_MODE   = 2'd0,
    CFG_WIDTH_TILES  = 2'd1,
    CFG_HEIGHT_TILES = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    mode_t      mode;
    logic [4:0] width_tiles;
    logic [4:0] height_tiles;
  } cfg_t;

  // Control of the address stage
  typedef struct packed {
    logic       valid;
    logic       is_write;
    logic       wr_en;
    logic       oor;
    mode_t      mode;
    logic [2:0] xsel;
  } s1_ctrl_t;

  typedef struct packed {
    logic [31:0] color_rgba;
    logic [3:0]  color_index;
    logic        out_of_range;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/tipf_channels.sv @@
// Valid/ready channel interfaces for input items, result items and config writes.
// Depends on tipf_pkg.
`default_nettype none

interface tipf_in_if;
  import tipf_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [BIDX_W-1:0] byte_index;
  logic [BYTE_W-1:0] byte_value;
  logic [X_W-1:0]    pixel_x;
  logic [Y_W-1:0]    pixel_y;
  modport source (output valid, operation, byte_index, byte_value, pixel_x, pixel_y,
                  input ready);
  modport sink   (input valid, operation, byte_index, byte_value, pixel_x, pixel_y,
                  output ready);
endinterface

interface tipf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] color_rgba;
  logic [3:0]  color_index;
  logic        out_of_range;
  modport source (output valid, color_rgba, color_index, out_of_range, input ready);
  modport sink   (input valid, color_rgba, color_index, out_of_range, output ready);
endinterface

interface tipf_cfg_if;
  import tipf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tipf_addr.sv @@
// Address stage: range check, tile address, store wrap; registers the store access.
// Depends on tipf_pkg.
`default_nettype none

module tipf_addr #(
  parameter int STORE_BYTES     = tipf_pkg::DEF_STORE_BYTES,
  parameter int MAX_WIDTH_TILES = tipf_pkg::DEF_MAX_WIDTH_TILES
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               accept,
  input  wire logic                               operation,
  input  wire logic [tipf_pkg::BIDX_W-1:0]        byte_index,
  input  wire logic [tipf_pkg::BYTE_W-1:0]        byte_value,
  input  wire logic [tipf_pkg::X_W-1:0]           pixel_x,
  input  wire logic [tipf_pkg::Y_W-1:0]           pixel_y,
  input  wire tipf_pkg::cfg_t                     cfg,
  output tipf_pkg::s1_ctrl_t                      s1_ctrl_r,
  output logic [$clog2(STORE_BYTES)-1:0]          s1_addr_r,
  output logic [tipf_pkg::BYTE_W-1:0]             s1_wdata_r
);
  import tipf_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  // Wide enough for eight times the store size
  localparam int RW = AW + 4;

  logic [4:0]        wt;
  logic              oor;
  logic [8:0]        prod;
  logic [TILE_W-1:0] tile;
  logic [LIN_W-1:0]  lin_addr;
  logic [RW-1:0]     red;
  logic [RW-1:0]     wr_ext;
  logic              wr_ok;
  logic [AW-1:0]     addr_nxt;
  s1_ctrl_t          s1_ctrl_nxt;

  function automatic logic [6:0] width_tiles_ext();
    width_tiles_ext = {2'b00, cfg.width_tiles};
  endfunction

  // Width clamp and range check
  always_comb begin
    wt  = (7'(width_tiles_ext()) > 7'(MAX_WIDTH_TILES)) ? 5'(MAX_WIDTH_TILES)
                                                         : cfg.width_tiles;
    oor = (pixel_x >= {wt, 3'b000}) || ({1'b0, pixel_y} >= {cfg.height_tiles, 3'b000});
  end

  // Tile number and linear byte address
  always_comb begin
    prod = pixel_y[6:3] * wt;
    tile = {1'b0, prod} + {5'b00000, pixel_x[7:3]};
    if (cfg.mode == MODE_4BPP) begin
      lin_addr = {tile, pixel_y[2:0], pixel_x[2:1]};
    end else begin
      lin_addr = {2'b00, tile, pixel_y[2:0]};
    end
  end

  // Wrap the read address into the store: restoring steps, quotient below 16
  always_comb begin
    red = RW'(lin_addr);
    for (int k = 3; k >= 0; k--) begin
      if (red >= (RW'(STORE_BYTES) << k)) begin
        red = red - (RW'(STORE_BYTES) << k);
      end
    end
  end

  // Writes beyond the store are dropped
  always_comb begin
    wr_ext   = RW'(byte_index);
    wr_ok    = wr_ext < RW'(STORE_BYTES);
    addr_nxt = (operation == OP_READ) ? red[AW-1:0] : wr_ext[AW-1:0];
  end

  always_comb begin
    s1_ctrl_nxt.valid    = accept;
    s1_ctrl_nxt.is_write = (operation == OP_WRITE);
    s1_ctrl_nxt.wr_en    = (operation == OP_WRITE) && wr_ok;
    s1_ctrl_nxt.oor      = oor;
    s1_ctrl_nxt.mode     = cfg.mode;
    s1_ctrl_nxt.xsel     = pixel_x[2:0];
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r.valid <= 1'b0;
    end else begin
      s1_ctrl_r.valid <= s1_ctrl_nxt.valid;
    end
    s1_ctrl_r.is_write <= s1_ctrl_nxt.is_write;
    s1_ctrl_r.wr_en    <= s1_ctrl_nxt.wr_en;
    s1_ctrl_r.oor      <= s1_ctrl_nxt.oor;
    s1_ctrl_r.mode     <= s1_ctrl_nxt.mode;
    s1_ctrl_r.xsel     <= s1_ctrl_nxt.xsel;
    s1_addr_r          <= addr_nxt;
    s1_wdata_r         <= byte_value;
  end

endmodule

`default_nettype wire

@@ hw/rtl/tipf_store.sv @@
// Single-port image byte store, one access per cycle, registered read data.
// Depends on tipf_pkg.
`default_nettype none

module tipf_store #(
  parameter int STORE_BYTES = tipf_pkg::DEF_STORE_BYTES
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(STORE_BYTES)-1:0] addr,
  input  wire logic [tipf_pkg::BYTE_W-1:0]  wdata,
  output logic [tipf_pkg::BYTE_W-1:0]       rdata_r
);
  import tipf_pkg::*;

  logic [BYTE_W-1:0] mem [STORE_BYTES];

  // Read-first single port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/tipf_result_fifo.sv @@
// Result queue between the decode stage and the output channel.
// Depends on tipf_pkg and the assertion macro header.
`default_nettype none

module tipf_result_fifo #(
  parameter int DEPTH = tipf_pkg::FIFO_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire tipf_pkg::result_t         push_data,
  input  wire logic                      pop,
  output tipf_pkg::result_t              head,
  output logic                           head_valid,
  output logic [$clog2(DEPTH+1)-1:0]     count_r
);
  import tipf_pkg::*;
  `include "tiled_indexed_pixel_fetch_core_macros.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t       entry [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_nxt;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr_r] <= push_data;
    end
  end

  assign head       = entry[rd_ptr_r];
  assign head_valid = (count_r != '0);

  `TIPF_ASSERT_IMPL(a_no_overflow, push, count_r < CW'(DEPTH), "result queue overflow")
  `TIPF_ASSERT_NEXT(a_cnt_up, push && !pop, count_r == $past(count_r) + 1'b1, "count not up")
  `TIPF_ASSERT_NEXT(a_cnt_dn, pop && !push, count_r == $past(count_r) - 1'b1, "count not down")

endmodule

`default_nettype wire

@@ hw/rtl/tiled_indexed_pixel_fetch_core.sv @@
// Top level of the tiled indexed pixel fetch: config registers, pipeline, decode.
// Depends on tipf_pkg, tipf_channels, tipf_addr, tipf_store, tipf_result_fifo.
//
//   channel  | dir | carries
//   ---------+-----+----------------------------------------------------------
//   in_ch    | in  | operation, byte_index, byte_value, pixel_x, pixel_y
//   out_ch   | out | color_rgba, color_index, out_of_range (one item per read)
//   cfg_ch   | in  | index, data (pixel_mode, width_tiles, height_tiles)
//
// One item per cycle while ready; the single store port takes one access a cycle.
// A read passes the address register, store read register and result queue.
// Writes give no result and land in the store from the address register.
// Up to FIFO_DEPTH reads may be outstanding; in_ch.ready drops when that many
// wait and none leaves. Reset clears control only; the store needs no clear pass.
`default_nettype none

module tiled_indexed_pixel_fetch_core #(
  parameter int STORE_BYTES     = tipf_pkg::DEF_STORE_BYTES,
  parameter int MAX_WIDTH_TILES = tipf_pkg::DEF_MAX_WIDTH_TILES
) (
  input wire logic   clk,
  input wire logic   rst_n,
  tipf_in_if.sink    in_ch,
  tipf_out_if.source out_ch,
  tipf_cfg_if.sink   cfg_ch
);
  import tipf_pkg::*;
  `include "tiled_indexed_pixel_fetch_core_macros.svh"

  localparam int AW = $clog2(STORE_BYTES);

  cfg_t                cfg_r;
  s1_ctrl_t            s1_ctrl_r;
  logic [AW-1:0]       s1_addr_r;
  logic [BYTE_W-1:0]   s1_wdata_r;
  logic [BYTE_W-1:0]   rd_byte;
  logic                s2_v_r;
  logic                s2_oor_r;
  mode_t               s2_mode_r;
  logic [2:0]          s2_xsel_r;
  logic [CREDIT_W-1:0] credit_r;
  logic [CREDIT_W-1:0] credit_nxt;
  logic [CREDIT_W-1:0] fifo_cnt;
  logic                in_accept;
  logic                rd_accept;
  logic                pop;
  logic                s1_rd;
  logic                bit_v;
  result_t             dec;
  result_t             head;
  logic                head_valid;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= MODE_4BPP;
      cfg_r.width_tiles  <= RST_WIDTH_TILES;
      cfg_r.height_tiles <= RST_HEIGHT_TILES;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PIXEL_MODE:   cfg_r.mode         <= mode_t'(cfg_ch.data[0]);
        CFG_WIDTH_TILES:  cfg_r.width_tiles  <= cfg_ch.data;
        CFG_HEIGHT_TILES: cfg_r.height_tiles <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input handshake: credit counts reads not yet delivered
  assign pop          = head_valid && out_ch.ready;
  assign in_ch.ready  = (credit_r < CREDIT_W'(FIFO_DEPTH)) || pop;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign rd_accept    = in_accept && (in_ch.operation == OP_READ);

  always_comb begin
    credit_nxt = credit_r;
    case ({rd_accept, pop})
      2'b10:   credit_nxt = credit_r + 1'b1;
      2'b01:   credit_nxt = credit_r - 1'b1;
      default: credit_nxt = credit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  // Address stage
  tipf_addr #(
    .STORE_BYTES     (STORE_BYTES),
    .MAX_WIDTH_TILES (MAX_WIDTH_TILES)
  ) u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .operation  (in_ch.operation),
    .byte_index (in_ch.byte_index),
    .byte_value (in_ch.byte_value),
    .pixel_x    (in_ch.pixel_x),
    .pixel_y    (in_ch.pixel_y),
    .cfg        (cfg_r),
    .s1_ctrl_r  (s1_ctrl_r),
    .s1_addr_r  (s1_addr_r),
    .s1_wdata_r (s1_wdata_r)
  );

  // Byte store
  tipf_store #(
    .STORE_BYTES (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .we      (s1_ctrl_r.valid && s1_ctrl_r.wr_en),
    .addr    (s1_addr_r),
    .wdata   (s1_wdata_r),
    .rdata_r (rd_byte)
  );

  // Read stage alongside the store access
  assign s1_rd = s1_ctrl_r.valid && !s1_ctrl_r.is_write;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_rd;
    end
    s2_oor_r  <= s1_ctrl_r.oor;
    s2_mode_r <= s1_ctrl_r.mode;
    s2_xsel_r <= s1_ctrl_r.xsel;
  end

  // Pixel decode: zeros when out of range, else palette nibble or black/white bit
  always_comb begin
    bit_v = rd_byte[~s2_xsel_r];
    if (s2_oor_r) begin
      dec.color_rgba   = '0;
      dec.color_index  = '0;
      dec.out_of_range = 1'b1;
    end else if (s2_mode_r == MODE_4BPP) begin
      dec.color_index  = s2_xsel_r[0] ? rd_byte[7:4] : rd_byte[3:0];
      dec.color_rgba   = PALETTE[dec.color_index];
      dec.out_of_range = 1'b0;
    end else begin
      dec.color_index  = {3'b000, bit_v};
      dec.color_rgba   = bit_v ? COLOR_BLACK : COLOR_WHITE;
      dec.out_of_range = 1'b0;
    end
  end

  // Result queue
  tipf_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s2_v_r),
    .push_data  (dec),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count_r    (fifo_cnt)
  );

  assign out_ch.valid        = head_valid;
  assign out_ch.color_rgba   = head.color_rgba;
  assign out_ch.color_index  = head.color_index;
  assign out_ch.out_of_range = head.out_of_range;

  `TIPF_ASSERT_IMPL(a_credit_match, 1'b1, credit_r == CREDIT_W'(s1_rd) + CREDIT_W'(s2_v_r) + fifo_cnt, "credit lost")
  `TIPF_ASSERT_IMPL(a_credit_bound, 1'b1, credit_r <= CREDIT_W'(FIFO_DEPTH), "credit above depth")
  `TIPF_ASSERT_NEXT(a_write_silent, s1_ctrl_r.valid && s1_ctrl_r.is_write, !s2_v_r, "write made a result")

endmodule

`default_nettype wire
